[rtl/core/mets_pkg.sv]
// Shared types and constants for the escape-time pixel unit.
// No dependencies; every module of the block imports this package.
package mets_pkg;

  // Widths of the fixed-point words and of the item fields
  localparam int WORD_BITS      = 64;
  localparam int STEP_BITS      = 63;
  localparam int HALF_BITS      = 32;
  localparam int PIX_BITS       = 12;
  localparam int ITER_BITS      = 16;
  localparam int COLOR_BITS     = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int FRAC_BITS_DEF  = 60;

  // Color map and escape constants
  localparam int LIMIT_RST    = 100;
  localparam int BRIGHT_SCALE = 255;
  localparam int BRIGHT_FLOOR = 20;
  localparam int RED_DIV      = 255 * 25;
  localparam int RED_GAIN     = 512;
  localparam int ESC_RADIUS   = 2;

  localparam logic [WORD_BITS-1:0] S64_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] S64_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_X_ORIGIN   = 3'd0,
    CFG_Y_ORIGIN   = 3'd1,
    CFG_X_STEP     = 3'd2,
    CFG_Y_STEP     = 3'd3,
    CFG_ITER_LIMIT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] x_origin;
    logic [WORD_BITS-1:0] y_origin;
    logic [STEP_BITS-1:0] x_step;
    logic [STEP_BITS-1:0] y_step;
    logic [ITER_BITS-1:0] iteration_limit;
  } mets_cfg_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] column;
    logic [PIX_BITS-1:0] row;
  } mets_in_t;

  typedef struct packed {
    logic [ITER_BITS-1:0]  iterations;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } mets_out_t;

  // Multiplier result scaling: fixed-point product or plain saturated product
  typedef enum logic {
    MUL_FIX = 1'b0,
    MUL_MAP = 1'b1
  } mul_mode_t;

  typedef struct packed {
    logic      go;
    mul_mode_t mode;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic                  done;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } col_rsp_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_RUN,
    MS_POST
  } mul_state_t;

  typedef enum logic [1:0] {
    CL_IDLE,
    CL_DIV,
    CL_LUT
  } col_state_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_MAP_X,
    SQ_MAP_Y,
    SQ_SQR_A,
    SQ_SQR_B,
    SQ_TEST,
    SQ_MUL_AB,
    SQ_UPDATE,
    SQ_COLOR
  } seq_state_t;

endpackage

[rtl/core/mets_mul.sv]
// Shared 64x64 signed-magnitude multiplier built on one 32x32 multiplier.
// Scales and saturates the product per request mode; uses mets_pkg.
module mets_mul
  import mets_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mul_req_t             req,
  input  logic [WORD_BITS-1:0] op_x,
  input  logic [WORD_BITS-1:0] op_y,
  output mul_rsp_t             rsp
);

  localparam int ACC_BITS = 2 * WORD_BITS;

  mul_state_t st_r, st_nxt;
  logic [2:0]             k_r;
  logic [WORD_BITS-1:0]   ux_r, uy_r;
  logic                   neg_r;
  mul_mode_t              mode_r;
  logic [WORD_BITS-1:0]   p_r;
  logic [ACC_BITS-1:0]    acc_r;
  logic [WORD_BITS-1:0]   res_r;
  logic                   done_r;

  logic                   load;
  logic                   run_done;
  logic [WORD_BITS-1:0]   ux, uy;
  logic [HALF_BITS-1:0]   mul_a, mul_b;
  logic [WORD_BITS-1:0]   prod;
  logic [ACC_BITS-1:0]    addend;
  logic                   sat;
  logic [WORD_BITS-1:0]   mag;
  logic [WORD_BITS-1:0]   res_nxt;

  // Take magnitudes of the signed operands
  assign ux = op_x[WORD_BITS-1] ? (~op_x + 1'b1) : op_x;
  assign uy = op_y[WORD_BITS-1] ? (~op_y + 1'b1) : op_y;

  // Next state and sequencing controls
  always_comb begin
    st_nxt   = st_r;
    load     = 1'b0;
    run_done = 1'b0;
    case (st_r)
      MS_IDLE: begin
        if (req.go && !done_r) begin
          load   = 1'b1;
          st_nxt = MS_RUN;
        end
      end
      MS_RUN: begin
        if (k_r == 3'd4) begin
          run_done = 1'b1;
          st_nxt   = MS_POST;
        end
      end
      MS_POST: st_nxt = MS_IDLE;
      default: st_nxt = MS_IDLE;
    endcase
  end

  // Select the partial product for this step
  always_comb begin
    case (k_r[1:0])
      2'd0: begin
        mul_a = ux_r[HALF_BITS-1:0];
        mul_b = uy_r[HALF_BITS-1:0];
      end
      2'd1: begin
        mul_a = ux_r[HALF_BITS-1:0];
        mul_b = uy_r[WORD_BITS-1:HALF_BITS];
      end
      2'd2: begin
        mul_a = ux_r[WORD_BITS-1:HALF_BITS];
        mul_b = uy_r[HALF_BITS-1:0];
      end
      default: begin
        mul_a = ux_r[WORD_BITS-1:HALF_BITS];
        mul_b = uy_r[WORD_BITS-1:HALF_BITS];
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Align the registered partial product of the previous step
  always_comb begin
    case (k_r)
      3'd1:       addend = {{WORD_BITS{1'b0}}, p_r};
      3'd2, 3'd3: addend = {{HALF_BITS{1'b0}}, p_r, {HALF_BITS{1'b0}}};
      3'd4:       addend = {p_r, {WORD_BITS{1'b0}}};
      default:    addend = '0;
    endcase
  end

  // Scale, saturate and apply sign
  always_comb begin
    if (mode_r == MUL_MAP) begin
      sat = |acc_r[ACC_BITS-1:WORD_BITS-1];
      mag = {1'b0, acc_r[WORD_BITS-2:0]};
    end else begin
      sat = |acc_r[ACC_BITS-1:FRAC_BITS+WORD_BITS-1];
      mag = {1'b0, acc_r[FRAC_BITS+WORD_BITS-2:FRAC_BITS]};
    end
    if (sat) begin
      mag = S64_MAX;
    end
    res_nxt = neg_r ? (~mag + 1'b1) : mag;
  end

  // Hold state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == MS_POST);
    end
  end

  // Advance the accumulation
  always_ff @(posedge clk) begin
    if (load) begin
      ux_r   <= ux;
      uy_r   <= uy;
      neg_r  <= (req.mode == MUL_FIX) && (op_x[WORD_BITS-1] != op_y[WORD_BITS-1]);
      mode_r <= req.mode;
      k_r    <= '0;
      acc_r  <= '0;
    end else if (st_r == MS_RUN) begin
      p_r   <= prod;
      acc_r <= acc_r + addend;
      if (!run_done) begin
        k_r <= k_r + 3'd1;
      end
    end
    if (st_r == MS_POST) begin
      res_r <= res_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

[rtl/core/mets_color.sv]
// Color map: brightness by restoring division, red and green from constant tables.
// Uses mets_pkg for widths, constants and the state type.
module mets_color
  import mets_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [ITER_BITS-1:0] n,
  input  logic [ITER_BITS-1:0] limit,
  output col_rsp_t             rsp
);

  localparam int DIV_W   = ITER_BITS + COLOR_BITS;
  localparam int LUT_LEN = 1 << COLOR_BITS;

  typedef logic [COLOR_BITS-1:0] lut8_t [LUT_LEN];

  function automatic lut8_t red_lut_f();
    lut8_t t;
    int    v;
    for (int b = 0; b < LUT_LEN; b++) begin
      v    = (b * b * RED_GAIN) / RED_DIV;
      t[b] = COLOR_BITS'((v % 256) % 255);
    end
    return t;
  endfunction

  function automatic lut8_t green_lut_f();
    lut8_t t;
    int    v;
    int    r;
    for (int b = 0; b < LUT_LEN; b++) begin
      v = BRIGHT_SCALE * b;
      r = 0;
      for (int k = 0; k < LUT_LEN; k++) begin
        if (k * k <= v) begin
          r = k;
        end
      end
      t[b] = COLOR_BITS'(r);
    end
    return t;
  endfunction

  localparam lut8_t RED_LUT   = red_lut_f();
  localparam lut8_t GREEN_LUT = green_lut_f();

  col_state_t st_r, st_nxt;
  logic [ITER_BITS-1:0]  rem_r;
  logic [COLOR_BITS-1:0] low_r;
  logic [COLOR_BITS-1:0] q_r;
  logic [2:0]            cnt_r;
  logic [COLOR_BITS-1:0] red_r, green_r, blue_r;
  logic                  done_r;

  logic                  load;
  logic [DIV_W-1:0]      dividend;
  logic [ITER_BITS:0]    rem_sh;
  logic [ITER_BITS:0]    diff;
  logic                  ge;
  logic [COLOR_BITS-1:0] bright;

  assign dividend = DIV_W'(n) * DIV_W'(BRIGHT_SCALE);

  // One quotient bit per cycle
  assign rem_sh = {rem_r, low_r[COLOR_BITS-1]};
  assign diff   = rem_sh - {1'b0, limit};
  assign ge     = (rem_sh >= {1'b0, limit});

  // Drop dim pixels to black
  assign bright = (q_r < COLOR_BITS'(BRIGHT_FLOOR)) ? '0 : q_r;

  // Next state
  always_comb begin
    st_nxt = st_r;
    load   = 1'b0;
    case (st_r)
      CL_IDLE: begin
        if (go && !done_r) begin
          load   = 1'b1;
          st_nxt = (n == limit) ? CL_LUT : CL_DIV;
        end
      end
      CL_DIV: begin
        if (cnt_r == 3'd7) begin
          st_nxt = CL_LUT;
        end
      end
      CL_LUT:  st_nxt = CL_IDLE;
      default: st_nxt = CL_IDLE;
    endcase
  end

  // Hold state and done strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CL_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == CL_LUT);
    end
  end

  // Divide and look up the channels
  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= dividend[DIV_W-1:COLOR_BITS];
      low_r <= dividend[COLOR_BITS-1:0];
      q_r   <= '0;
      cnt_r <= '0;
    end else if (st_r == CL_DIV) begin
      rem_r <= ge ? diff[ITER_BITS-1:0] : rem_sh[ITER_BITS-1:0];
      low_r <= {low_r[COLOR_BITS-2:0], 1'b0};
      q_r   <= {q_r[COLOR_BITS-2:0], ge};
      cnt_r <= cnt_r + 3'd1;
    end
    if (st_r == CL_LUT) begin
      red_r   <= RED_LUT[bright];
      green_r <= GREEN_LUT[bright];
      blue_r  <= bright;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.red   = red_r;
  assign rsp.green = green_r;
  assign rsp.blue  = blue_r;

endmodule

[rtl/core/mets_seq.sv]
// Iteration sequencer: maps the pixel, runs z = z*z + c on the shared multiplier,
// tests escape and hands the count to the color map. Uses mets_pkg.
module mets_seq
  import mets_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mets_in_t             in_data,
  input  mets_cfg_t            cfg,
  output mul_req_t             mul_req,
  output logic [WORD_BITS-1:0] mul_x,
  output logic [WORD_BITS-1:0] mul_y,
  input  mul_rsp_t             mul_rsp,
  output logic                 col_go,
  output logic [ITER_BITS-1:0] col_n,
  input  col_rsp_t             col_rsp,
  output logic                 out_strobe,
  output mets_out_t            out_data
);

  localparam logic [WORD_BITS-1:0] FOUR =
    WORD_BITS'(ESC_RADIUS * ESC_RADIUS) << FRAC_BITS;

  function automatic logic [WORD_BITS-1:0] sat_add(
    input logic [WORD_BITS-1:0] a,
    input logic [WORD_BITS-1:0] b
  );
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? S64_MIN : S64_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] sat_sub(
    input logic [WORD_BITS-1:0] a,
    input logic [WORD_BITS-1:0] b
  );
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? S64_MIN : S64_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  seq_state_t st_r, st_nxt;
  logic [PIX_BITS-1:0]  col_r, row_r;
  logic [WORD_BITS-1:0] cr_r, ci_r;
  logic [WORD_BITS-1:0] a_r, b_r;
  logic [WORD_BITS-1:0] aa_r, bb_r;
  logic [ITER_BITS-1:0] n_r;
  logic                 first_r;
  logic                 strobe_r;
  mets_out_t            out_r;

  logic [WORD_BITS-1:0] mag_sq;
  logic                 escape;
  logic [ITER_BITS-1:0] n_inc;
  logic [WORD_BITS-1:0] map_sum;

  // Escape test on the squares of the latest z
  assign mag_sq = sat_add(aa_r, bb_r);
  assign escape = !first_r && ($signed(mag_sq) > $signed(FOUR));
  assign n_inc  = first_r ? n_r : (n_r + 1'b1);

  // Offset the window origin by the scaled index
  assign map_sum = sat_add((st_r == SQ_MAP_X) ? cfg.x_origin : cfg.y_origin, mul_rsp.res);

  // Next state and unit requests
  always_comb begin
    st_nxt       = st_r;
    mul_req.go   = 1'b0;
    mul_req.mode = MUL_FIX;
    mul_x        = a_r;
    mul_y        = a_r;
    col_go       = 1'b0;
    case (st_r)
      SQ_IDLE: begin
        if (start) begin
          st_nxt = SQ_MAP_X;
        end
      end
      SQ_MAP_X: begin
        mul_req.go   = 1'b1;
        mul_req.mode = MUL_MAP;
        mul_x        = {{(WORD_BITS-PIX_BITS){1'b0}}, col_r};
        mul_y        = {1'b0, cfg.x_step};
        if (mul_rsp.done) begin
          st_nxt = SQ_MAP_Y;
        end
      end
      SQ_MAP_Y: begin
        mul_req.go   = 1'b1;
        mul_req.mode = MUL_MAP;
        mul_x        = {{(WORD_BITS-PIX_BITS){1'b0}}, row_r};
        mul_y        = {1'b0, cfg.y_step};
        if (mul_rsp.done) begin
          st_nxt = SQ_SQR_A;
        end
      end
      SQ_SQR_A: begin
        mul_req.go = 1'b1;
        if (mul_rsp.done) begin
          st_nxt = SQ_SQR_B;
        end
      end
      SQ_SQR_B: begin
        mul_req.go = 1'b1;
        mul_x      = b_r;
        mul_y      = b_r;
        if (mul_rsp.done) begin
          st_nxt = SQ_TEST;
        end
      end
      SQ_TEST: begin
        if (escape || (n_inc == cfg.iteration_limit)) begin
          st_nxt = SQ_COLOR;
        end else begin
          st_nxt = SQ_MUL_AB;
        end
      end
      SQ_MUL_AB: begin
        mul_req.go = 1'b1;
        mul_y      = b_r;
        if (mul_rsp.done) begin
          st_nxt = SQ_UPDATE;
        end
      end
      SQ_UPDATE: st_nxt = SQ_SQR_A;
      SQ_COLOR: begin
        col_go = 1'b1;
        if (col_rsp.done) begin
          st_nxt = SQ_IDLE;
        end
      end
      default: st_nxt = SQ_IDLE;
    endcase
  end

  // Hold state and output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= SQ_IDLE;
      strobe_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      strobe_r <= (st_r == SQ_COLOR) && col_rsp.done;
    end
  end

  // Advance the iteration datapath
  always_ff @(posedge clk) begin
    case (st_r)
      SQ_IDLE: begin
        if (start) begin
          col_r   <= in_data.column;
          row_r   <= in_data.row;
          n_r     <= '0;
          first_r <= 1'b1;
        end
      end
      SQ_MAP_X: begin
        if (mul_rsp.done) begin
          cr_r <= map_sum;
          a_r  <= map_sum;
        end
      end
      SQ_MAP_Y: begin
        if (mul_rsp.done) begin
          ci_r <= map_sum;
          b_r  <= map_sum;
        end
      end
      SQ_SQR_A: begin
        if (mul_rsp.done) begin
          aa_r <= mul_rsp.res;
        end
      end
      SQ_SQR_B: begin
        if (mul_rsp.done) begin
          bb_r <= mul_rsp.res;
        end
      end
      SQ_TEST: begin
        first_r <= 1'b0;
        if (!escape) begin
          n_r <= n_inc;
        end
      end
      SQ_MUL_AB: begin
        if (mul_rsp.done) begin
          a_r <= sat_sub(aa_r, bb_r);
          b_r <= sat_add(mul_rsp.res, mul_rsp.res);
        end
      end
      SQ_UPDATE: begin
        a_r <= sat_add(a_r, cr_r);
        b_r <= sat_add(b_r, ci_r);
      end
      SQ_COLOR: begin
        if (col_rsp.done) begin
          out_r.iterations <= n_r;
          out_r.red        <= col_rsp.red;
          out_r.green      <= col_rsp.green;
          out_r.blue       <= col_rsp.blue;
        end
      end
      default: ;
    endcase
  end

  assign busy       = (st_r != SQ_IDLE);
  assign col_n      = n_r;
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

[rtl/core/mandelbrot_escape_time_pixel_unit.sv]
// Escape-time pixel unit: configuration registers plus sequencer, multiplier, color map.
// Each pixel runs m z updates: m = n+1 for an escaping point, where n is the reported count;
// a point that reaches the limit runs m = n updates and skips the divide in the color map.
// One 32x32 multiplier, used for three 64-bit products per update, sets the latency.
// One pixel at a time; busy drops in the cycle out_strobe rises. Results cannot be stalled.
// Synchronous active-low reset idles the unit and loads the default window and limit.
module mandelbrot_escape_time_pixel_unit
  import mets_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  mets_in_t                  in_data,
  output logic                      out_strobe,
  output mets_out_t                 out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]      cfg_data
);

  localparam logic [WORD_BITS-1:0] ORIGIN_RST = ~(WORD_BITS'(2) << FRAC_BITS) + 1'b1;
  localparam logic [STEP_BITS-1:0] STEP_RST   = STEP_BITS'(1) << (FRAC_BITS - 8);

  mets_cfg_t            cfg_r;
  mul_req_t             mul_req;
  mul_rsp_t             mul_rsp;
  logic [WORD_BITS-1:0] mul_x, mul_y;
  logic                 col_go;
  logic [ITER_BITS-1:0] col_n;
  col_rsp_t             col_rsp;

  assign cfg_ready = 1'b1;

  // Write configuration words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin        <= ORIGIN_RST;
      cfg_r.y_origin        <= ORIGIN_RST;
      cfg_r.x_step          <= STEP_RST;
      cfg_r.y_step          <= STEP_RST;
      cfg_r.iteration_limit <= ITER_BITS'(LIMIT_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_ORIGIN:   cfg_r.x_origin        <= cfg_data;
        CFG_Y_ORIGIN:   cfg_r.y_origin        <= cfg_data;
        CFG_X_STEP:     cfg_r.x_step          <= cfg_data[STEP_BITS-1:0];
        CFG_Y_STEP:     cfg_r.y_step          <= cfg_data[STEP_BITS-1:0];
        CFG_ITER_LIMIT: cfg_r.iteration_limit <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  mets_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .mul_req    (mul_req),
    .mul_x      (mul_x),
    .mul_y      (mul_y),
    .mul_rsp    (mul_rsp),
    .col_go     (col_go),
    .col_n      (col_n),
    .col_rsp    (col_rsp),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  mets_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .op_x  (mul_x),
    .op_y  (mul_y),
    .rsp   (mul_rsp)
  );

  mets_color u_color (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (col_go),
    .n     (col_n),
    .limit (cfg_r.iteration_limit),
    .rsp   (col_rsp)
  );

endmodule
